[rtl/zcle_pkg.sv]
`default_nettype none

package zcle_pkg;

  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 16;
  localparam int WIN_W      = 20;
  localparam int THR_W      = 24;
  localparam int PER_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Merge weight is Q.24; the weight magnitude fits in WIN_W + PER_W bits.
  localparam int Q_FRAC   = 24;
  localparam int MW_W     = WIN_W + PER_W;
  localparam int CHUNK_A  = 24;
  localparam int CHUNK_B  = 18;
  localparam int B_CHUNKS = MW_W / CHUNK_B;
  localparam int PROD_W   = CHUNK_A + CHUNK_B;

  localparam logic                  RST_STEREO = 1'b0;
  localparam logic [WIN_W-1:0]      RST_WINDOW = '0;
  localparam logic [THR_W-1:0]      RST_THRESH = THR_W'(1);
  localparam logic [PER_W-1:0]      RST_PERIOD = PER_W'(380);
  localparam logic [COUNT_W-1:0]    COUNT_MAX  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEREO = 2'd0,
    CFG_WINDOW = 2'd1,
    CFG_THRESH = 2'd2,
    CFG_PERIOD = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    EV_NEW   = 1'b0,
    EV_MERGE = 1'b1
  } event_kind_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic wgt;
    logic mag;
    logic mul;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic merge;
    logic emit_new;
    logic mul_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[rtl/zcle_ctrl.sv]
`default_nettype none

module zcle_ctrl import zcle_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_WGT  = 7'b0000100,
    S_MAG  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (st.merge) begin
          state_nxt = S_WGT;
        end else if (st.emit_new) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WGT: begin
        cmd.wgt   = 1'b1;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (st.mul_last) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

[rtl/zcle_dp.sv]
`default_nettype none

module zcle_dp import zcle_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int AREA_BITS   = 40
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cmd_t                          cmd,
  output status_t                            st,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right_sample,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_event_kind,
  output logic [TIME_W-1:0]                  out_reflection_time,
  output logic signed [AREA_BITS-1:0]        out_reflection_area,
  output logic [COUNT_W-1:0]                 out_reflection_number
);

  localparam int SW       = SAMPLE_BITS;
  localparam int AW       = AREA_BITS;
  localparam int A_CHUNKS = (AW + CHUNK_A - 1) / CHUNK_A;
  localparam int MA_W     = A_CHUNKS * CHUNK_A;
  localparam int ACC_W    = MA_W + MW_W;
  localparam int RW       = ACC_W - Q_FRAC;
  localparam int STEPS    = A_CHUNKS * B_CHUNKS;
  localparam int STEP_W   = $clog2(STEPS);
  localparam int W_W      = MW_W + 2;

  localparam logic [AW-1:0] AREA_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0] AREA_MIN = {1'b1, {(AW-1){1'b0}}};

  logic                stereo_r;
  logic [WIN_W-1:0]    window_r;
  logic [THR_W-1:0]    thresh_r;
  logic [PER_W-1:0]    period_r;

  logic [SW-1:0]       left_r;
  logic [SW-1:0]       right_r;
  logic [AW-1:0]       lobe_r;
  logic [SW-1:0]       prev_r;
  logic [TIME_W-1:0]   cnt_r;
  logic [TIME_W-1:0]   ltime_r;
  logic [AW-1:0]       larea_r;
  logic [COUNT_W-1:0]  count_r;
  logic                kind_r;

  logic [WIN_W-1:0]    elapsed_r;
  logic [MW_W-1:0]     prod_r;
  logic [MA_W-1:0]     ma_r;
  logic                lneg_r;
  logic                neg_r;
  logic [MW_W-1:0]     mw_r;
  logic [STEP_W-1:0]   step_r;
  logic [ACC_W-1:0]    acc_r;
  logic                out_valid_r;

  logic [SW:0]         pair_sum;
  logic [SW-1:0]       sample;
  logic [AW:0]         sum_wide;
  logic [AW-1:0]       sum_new;
  logic                crossing;
  logic                first;
  logic [TIME_W-1:0]   elapsed;
  logic                in_window;
  logic                opposite;
  logic [AW:0]         diff;
  logic [AW:0]         diff_mag;
  logic                over_thr;
  logic                first_hit;
  logic                new_ok;
  logic                merge;
  logic [AW-1:0]       lobe_mag;

  logic [W_W-1:0]      w_val;
  logic [W_W-1:0]      w_mag;
  logic [STEP_W-1:0]   a_idx;
  logic                b_idx;
  logic [CHUNK_A-1:0]  a_chunk;
  logic [CHUNK_B-1:0]  b_chunk;
  logic [PROD_W-1:0]   pp;

  logic [RW:0]         r_ext;
  logic [RW:0]         term;
  logic [RW+1:0]       total;
  logic [RW+2-AW:0]    upper;
  logic [AW-1:0]       area_merged;

  // Stereo average is a floor shift of the pair sum.
  assign pair_sum = {left_r[SW-1], left_r} + {right_r[SW-1], right_r};
  assign sample   = stereo_r ? pair_sum[SW:1] : left_r;

  assign sum_wide = {lobe_r[AW-1], lobe_r} + {{(AW+1-SW){sample[SW-1]}}, sample};
  always_comb begin
    if (sum_wide[AW] != sum_wide[AW-1]) begin
      sum_new = sum_wide[AW] ? AREA_MIN : AREA_MAX;
    end else begin
      sum_new = sum_wide[AW-1:0];
    end
  end

  assign crossing = (!sample[SW-1] && (sample != '0) && prev_r[SW-1]) ||
                    (sample[SW-1] && !prev_r[SW-1] && (prev_r != '0));
  assign first     = (count_r == '0);
  assign elapsed   = cnt_r - ltime_r;
  assign in_window = (elapsed < {{(TIME_W-WIN_W){1'b0}}, window_r});

  assign opposite = (!larea_r[AW-1] && (larea_r != '0) && sum_new[AW-1]) ||
                    (larea_r[AW-1] && !sum_new[AW-1] && (sum_new != '0));
  assign diff     = {sum_new[AW-1], sum_new} - {larea_r[AW-1], larea_r};
  assign diff_mag = diff[AW] ? (~diff + 1'b1) : diff;
  assign over_thr = (diff_mag > (AW+1)'(thresh_r));

  assign first_hit = crossing && first;
  assign merge     = crossing && !first && in_window;
  assign new_ok    = crossing && !first && !in_window && opposite && over_thr;
  assign lobe_mag  = sum_new[AW-1] ? (~sum_new + 1'b1) : sum_new;

  // Weight is one minus the elapsed time times the period, signed Q.24.
  assign w_val = W_W'(1 << Q_FRAC) - {2'b00, prod_r};
  assign w_mag = w_val[W_W-1] ? (~w_val + 1'b1) : w_val;

  // One partial product of the lobe magnitude and the weight magnitude per cycle.
  assign a_idx   = step_r >> 1;
  assign b_idx   = step_r[0];
  assign a_chunk = CHUNK_A'(ma_r >> (CHUNK_A * a_idx));
  assign b_chunk = CHUNK_B'(mw_r >> (CHUNK_B * b_idx));
  assign pp      = PROD_W'(a_chunk) * PROD_W'(b_chunk);

  assign r_ext = {1'b0, acc_r[ACC_W-1:Q_FRAC]};
  assign term  = neg_r ? (~r_ext + 1'b1) : r_ext;
  assign total = {{(RW+2-AW){larea_r[AW-1]}}, larea_r} + {term[RW], term};
  assign upper = total[RW+1:AW-1];
  always_comb begin
    if ((&upper) || !(|upper)) begin
      area_merged = total[AW-1:0];
    end else begin
      area_merged = total[RW+1] ? AREA_MIN : AREA_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= RST_STEREO;
      window_r <= RST_WINDOW;
      thresh_r <= RST_THRESH;
      period_r <= RST_PERIOD;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STEREO: stereo_r <= cfg_data[0];
        CFG_WINDOW: window_r <= cfg_data[WIN_W-1:0];
        CFG_THRESH: thresh_r <= cfg_data[THR_W-1:0];
        CFG_PERIOD: period_r <= cfg_data[PER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lobe_r  <= '0;
      prev_r  <= '0;
      cnt_r   <= '0;
      ltime_r <= '0;
      larea_r <= '0;
      count_r <= '0;
    end else begin
      if (cmd.eval) begin
        lobe_r <= crossing ? '0 : sum_new;
        prev_r <= sample;
        cnt_r  <= cnt_r + 1'b1;
        if (first_hit || new_ok) begin
          ltime_r <= cnt_r;
          larea_r <= sum_new;
          if (first) begin
            count_r <= COUNT_W'(1);
          end else if (count_r != COUNT_MAX) begin
            count_r <= count_r + 1'b1;
          end
        end
      end
      if (cmd.acc) begin
        larea_r <= area_merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= in_left_sample;
      right_r <= in_right_sample;
    end
    if (cmd.eval) begin
      kind_r    <= merge ? EV_MERGE : EV_NEW;
      elapsed_r <= elapsed[WIN_W-1:0];
      ma_r      <= MA_W'(lobe_mag);
      lneg_r    <= sum_new[AW-1];
    end
    if (cmd.wgt) begin
      prod_r <= MW_W'(elapsed_r) * MW_W'(period_r);
    end
    if (cmd.mag) begin
      mw_r   <= w_mag[MW_W-1:0];
      neg_r  <= lneg_r ^ w_val[W_W-1];
      step_r <= '0;
      acc_r  <= '0;
    end
    if (cmd.mul) begin
      acc_r  <= acc_r + (ACC_W'(pp) << (CHUNK_A * a_idx + CHUNK_B * b_idx));
      step_r <= step_r + 1'b1;
    end
    if (cmd.emit) begin
      out_event_kind        <= kind_r;
      out_reflection_time   <= ltime_r;
      out_reflection_area   <= larea_r;
      out_reflection_number <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign st.merge    = merge;
  assign st.emit_new = first_hit || new_ok;
  assign st.mul_last = (step_r == STEP_W'(STEPS - 1));
  assign st.out_free = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

[rtl/zero_crossing_lobe_extractor.sv]
// An item that ends no lobe goes through evaluation back to idle; a new reflection goes
// from evaluation to the emit state; a merge first passes the weight, magnitude, multiply
// and accumulate states. The next item is stalled until the last is done, and emit waits
// while output is held; a 24x18 multiplier builds the merge product one partial a cycle.
// Synchronous active-low reset clears all lobe and reflection state and loads the
// register defaults; the output register holds one result while the next item runs.
`default_nettype none

module zero_crossing_lobe_extractor import zcle_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int AREA_BITS   = 40
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_event_kind,
  output logic [TIME_W-1:0]                  out_reflection_time,
  output logic signed [AREA_BITS-1:0]        out_reflection_area,
  output logic [COUNT_W-1:0]                 out_reflection_number,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  zcle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  zcle_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .AREA_BITS   (AREA_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .st                    (st),
    .in_left_sample        (in_left_sample),
    .in_right_sample       (in_right_sample),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_event_kind        (out_event_kind),
    .out_reflection_time   (out_reflection_time),
    .out_reflection_area   (out_reflection_area),
    .out_reflection_number (out_reflection_number)
  );

endmodule

`default_nettype wire

[rtl/zcle_checker.sv]
`default_nettype none

module zcle_checker #(
  parameter int AREA_BITS = 40
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic                 out_event_kind,
  input wire logic [31:0]          out_reflection_time,
  input wire logic [AREA_BITS-1:0] out_reflection_area,
  input wire logic [15:0]          out_reflection_number
);

  // After reset the block is empty and ready for an item.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty and ready after reset");

  // Items are worked one at a time, so an accepted item blocks the next one.
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while one is in progress");

  // A result can only appear while an item is being worked.
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result presented with no item in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind) &&
      $stable(out_reflection_time) && $stable(out_reflection_area) &&
      $stable(out_reflection_number))
    else $error("stalled result changed");

endmodule

bind zero_crossing_lobe_extractor zcle_checker #(
  .AREA_BITS (AREA_BITS)
) u_zcle_checker (.*);

`default_nettype wire

[bench/tb_top.sv]
module tb_top;
  import zcle_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int AREA_W = 40;
  localparam longint AREA_HI = (longint'(1) <<< (AREA_W - 1)) - 1;
  localparam longint AREA_LO = -AREA_HI - 1;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef struct {
    event_kind_t kind;
    logic [TIME_W-1:0] at_sample;
    logic signed [AREA_W-1:0] area;
    logic [COUNT_W-1:0] number;
  } reflection_event_t;

  class reflection_scoreboard;
    bit stereo;
    bit [WIN_W-1:0] window;
    bit [THR_W-1:0] threshold;
    bit [PER_W-1:0] period;
    longint lobe_area;
    int prior_sample;
    bit [TIME_W-1:0] sample_index;
    bit [TIME_W-1:0] refl_time;
    longint refl_area;
    bit [COUNT_W-1:0] refl_count;
    reflection_event_t awaited[$];
    int mismatches;

    function new();
      stereo = RST_STEREO;
      window = RST_WINDOW;
      threshold = RST_THRESH;
      period = RST_PERIOD;
      lobe_area = 0;
      prior_sample = 0;
      sample_index = '0;
      refl_time = '0;
      refl_area = 0;
      refl_count = '0;
      mismatches = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_STEREO: stereo = value[0];
        CFG_WINDOW: window = value[WIN_W-1:0];
        CFG_THRESH: threshold = value[THR_W-1:0];
        CFG_PERIOD: period = value[PER_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_area(longint v);
      if (v > AREA_HI) return AREA_HI;
      if (v < AREA_LO) return AREA_LO;
      return v;
    endfunction

    // Product of lobe and Q.24 weight, scaled down and truncated toward zero.
    function longint weigh_lobe(longint lobe, longint w);
      logic signed [95:0] a;
      logic signed [95:0] b;
      logic signed [95:0] scale;
      logic signed [95:0] q;
      a = 96'(lobe);
      b = 96'(w);
      scale = 96'sd1 <<< Q_FRAC;
      q = (a * b) / scale;
      return longint'(q);
    endfunction

    function void note_frame(logic signed [SAMPLE_W-1:0] left,
                             logic signed [SAMPLE_W-1:0] right);
      int level;
      int total;
      bit [TIME_W-1:0] elapsed;
      longint span;
      longint per;
      longint w;
      longint gap;
      longint limit;
      bit fire;
      reflection_event_t ev;
      level = left;
      if (stereo) begin
        total = left;
        total = total + right;
        level = total >>> 1;
      end
      lobe_area = clamp_area(lobe_area + level);
      fire = 1'b0;
      ev.kind = EV_NEW;
      if ((level > 0 && prior_sample < 0) || (level < 0 && prior_sample > 0)) begin
        if (refl_count == '0) begin
          refl_time = sample_index;
          refl_area = lobe_area;
          refl_count = COUNT_W'(1);
          fire = 1'b1;
        end else begin
          elapsed = sample_index - refl_time;
          if (elapsed < TIME_W'(window)) begin
            span = elapsed;
            per = period;
            w = (longint'(1) <<< Q_FRAC) - span * per;
            refl_area = clamp_area(refl_area + weigh_lobe(lobe_area, w));
            ev.kind = EV_MERGE;
            fire = 1'b1;
          end else if ((refl_area > 0 && lobe_area < 0) || (refl_area < 0 && lobe_area > 0)) begin
            gap = lobe_area - refl_area;
            if (gap < 0) gap = -gap;
            limit = threshold;
            if (gap > limit) begin
              refl_time = sample_index;
              refl_area = lobe_area;
              if (refl_count != COUNT_MAX) refl_count = refl_count + 1'b1;
              fire = 1'b1;
            end
          end
        end
        lobe_area = 0;
      end
      if (fire) begin
        ev.at_sample = refl_time;
        ev.area = refl_area[AREA_W-1:0];
        ev.number = refl_count - 1'b1;
        awaited.push_back(ev);
      end
      sample_index = sample_index + 1'b1;
      prior_sample = level;
    endfunction

    function void check_result(logic kind, logic [TIME_W-1:0] at_sample,
                               logic signed [AREA_W-1:0] area, logic [COUNT_W-1:0] number);
      reflection_event_t ev;
      if (awaited.size() == 0) begin
        $error("unexpected result: event_kind %0d reflection_time %0d area %0d number %0d",
               kind, at_sample, area, number);
        mismatches++;
        return;
      end
      ev = awaited.pop_front();
      if (kind !== ev.kind) begin
        $error("event_kind: expected %0d, actual %0d", ev.kind, kind);
        mismatches++;
      end
      if (at_sample !== ev.at_sample) begin
        $error("reflection_time: expected %0d, actual %0d", ev.at_sample, at_sample);
        mismatches++;
      end
      if (area !== ev.area) begin
        $error("reflection_area: expected %0d, actual %0d", ev.area, area);
        mismatches++;
      end
      if (number !== ev.number) begin
        $error("reflection_number: expected %0d, actual %0d", ev.number, number);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_left_sample = '0;
  logic signed [SAMPLE_W-1:0] in_right_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_event_kind;
  logic [TIME_W-1:0] out_reflection_time;
  logic signed [AREA_W-1:0] out_reflection_area;
  logic [COUNT_W-1:0] out_reflection_number;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_STEREO;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  reflection_scoreboard sb;
  bit idle_on = 1'b0;
  bit hold_request = 1'b0;
  int frames_sent = 0;

  zero_crossing_lobe_extractor #(
    .SAMPLE_BITS(SAMPLE_W),
    .AREA_BITS(AREA_W)
  ) dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_event_kind, out_reflection_time, out_reflection_area,
                      out_reflection_number);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_frame(logic signed [SAMPLE_W-1:0] left,
                            logic signed [SAMPLE_W-1:0] right);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_sample <= left;
    in_right_sample <= right;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_frame(left, right);
    frames_sent++;
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_register(idx, value);
  endtask

  task automatic configure(bit stereo_on, logic [WIN_W-1:0] win, logic [THR_W-1:0] thr,
                           logic [PER_W-1:0] per);
    write_register(CFG_STEREO, CFG_DATA_W'(stereo_on));
    write_register(CFG_WINDOW, CFG_DATA_W'(win));
    write_register(CFG_THRESH, CFG_DATA_W'(thr));
    write_register(CFG_PERIOD, CFG_DATA_W'(per));
    cfg_valid <= 1'b0;
  endtask

  // The block may still be busy on an item with no result, so wait on after the queue empties.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic random_setting();
    logic [WIN_W-1:0] win;
    logic [THR_W-1:0] thr;
    logic [PER_W-1:0] per;
    case ($urandom_range(0, 3))
      0: win = '0;
      1: win = '1;
      2: win = WIN_W'($urandom_range(1, 8));
      default: win = WIN_W'($urandom_range(1, 300));
    endcase
    case ($urandom_range(0, 3))
      0: thr = '0;
      1: thr = '1;
      2: thr = THR_W'($urandom_range(1, 100));
      default: thr = THR_W'($urandom_range(100, 200000));
    endcase
    case ($urandom_range(0, 3))
      0: per = PER_W'(1);
      1: per = '1;
      2: per = RST_PERIOD;
      default: per = PER_W'($urandom_range(1, 65535));
    endcase
    configure(1'($urandom_range(0, 1)), win, thr, per);
  endtask

  task automatic random_phase(int frames);
    int sent;
    int len;
    int mag;
    int v;
    int u;
    bit positive;
    sent = 0;
    positive = 1'($urandom_range(0, 1));
    while (sent < frames) begin
      if ($urandom_range(0, 9) == 0) begin
        send_frame(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        sent++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(10, 60))
                                          : int'($urandom_range(1, 6));
        case ($urandom_range(0, 3))
          0: mag = 32767;
          1: mag = 200;
          default: mag = int'($urandom_range(1, 32767));
        endcase
        for (int i = 0; i < len; i++) begin
          v = int'($urandom_range(1, mag));
          u = int'($urandom_range(0, mag));
          send_frame(SAMPLE_W'(positive ? v : -v), SAMPLE_W'(positive ? u : -u));
          sent++;
        end
        if ($urandom_range(0, 5) != 0) positive = !positive;
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    int v;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    // A first lobe of zero area, then lobes that cannot beat a zero reflection.
    send_frame(16'sd3, SAMPLE_MAX);
    send_frame(-16'sd3, SAMPLE_MIN);
    send_frame(SAMPLE_MAX, 16'sd0);
    send_frame(SAMPLE_MIN, 16'sd0);
    send_frame(16'sd0, 16'sd1);
    send_frame(16'sd5, -16'sd1);
    send_frame(-16'sd5, SAMPLE_MAX);
    settle();

    configure(1'b1, '1, '0, '1);
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MIN);
    send_frame(-16'sd1, 16'sd0);
    send_frame(16'sd1, 16'sd0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(16'sd100, -16'sd50);
    send_frame(-16'sd200, -16'sd300);
    send_frame(16'sd7, 16'sd8);
    settle();

    configure(1'b0, 20'd4, '1, PER_W'(1));
    send_frame(16'sd100, 16'sd0);
    send_frame(16'sd100, 16'sd0);
    send_frame(-16'sd50, 16'sd0);
    send_frame(16'sd30, 16'sd0);
    send_frame(-16'sd1000, 16'sd0);
    send_frame(SAMPLE_MAX, 16'sd0);
    settle();

    phase = 0;
    while (frames_sent < 760) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        idle_on = 1'b1;
        configure(1'b0, '0, '0, RST_PERIOD);
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) begin
          v = int'($urandom_range(1, 32767));
          send_frame(SAMPLE_W'(i[0] ? -v : v), SAMPLE_W'($urandom));
        end
      end else begin
        random_setting();
        random_phase(int'($urandom_range(40, 120)));
      end
      settle();
      phase++;
    end

    // The last stretch runs with no idling on either side.
    idle_on = 1'b0;
    random_setting();
    random_phase(60);
    settle();

    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
